@@ rtl/core/ame_pkg.sv @@
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types and codes for the accumulator machine execute block.
// ----------------------------------------------------------------------------
package ame_pkg;

    // Width of the instruction counter
    localparam int CNT_W = 32;

    // Function codes
    localparam logic [3:0] FN_SET   = 4'd0;
    localparam logic [3:0] FN_LDR   = 4'd1;
    localparam logic [3:0] FN_ADD   = 4'd2;
    localparam logic [3:0] FN_INC   = 4'd3;
    localparam logic [3:0] FN_DEC   = 4'd4;
    localparam logic [3:0] FN_STR   = 4'd5;
    localparam logic [3:0] FN_SHW   = 4'd6;
    localparam logic [3:0] FN_PAUSE = 4'd7;
    localparam logic [3:0] FN_END   = 4'd8;

    // Show sources
    localparam logic [2:0] SRC_ACC = 3'd0;
    localparam logic [2:0] SRC_CNT = 3'd1;
    localparam logic [2:0] SRC_MAR = 3'd2;
    localparam logic [2:0] SRC_MDR = 3'd3;
    localparam logic [2:0] SRC_RUN = 3'd4;
    localparam logic [2:0] SRC_MEM = 3'd5;

    // Block phase: memory clearing after reset, then normal running
    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } t_ame_phase;

    // One pre-decoded instruction
    typedef struct packed {
        logic [3:0]         func;
        logic               first_present;
        logic [7:0]         first_addr;
        logic               second_present;
        logic [7:0]         second_addr;
        logic               third_present;
        logic [7:0]         third_addr;
        logic signed [31:0] immediate;
        logic [2:0]         show_source;
    } t_ame_instr;

    // One result
    typedef struct packed {
        logic               shown;
        logic signed [31:0] shown_value;
        logic               halted;
    } t_ame_result;

endpackage

@@ rtl/core/ame_channels.sv @@
// ----------------------------------------------------------------------------
// ame_channels
// Valid/ready channels carrying instructions into and results out of the block.
// ----------------------------------------------------------------------------
interface ame_in_if import ame_pkg::*; ();
    logic       valid;
    logic       ready;
    t_ame_instr payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ame_out_if import ame_pkg::*; ();
    logic        valid;
    logic        ready;
    t_ame_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/ame_ram.sv @@
// ----------------------------------------------------------------------------
// ame_ram
// Generic RAM: one write port, two read ports with enable and registered data.
// ----------------------------------------------------------------------------
module ame_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/ame_exec.sv @@
// ----------------------------------------------------------------------------
// ame_exec
// Execute stage: operand forwarding, machine registers, write-back and the
// result register.
// ----------------------------------------------------------------------------
module ame_exec import ame_pkg::*; #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_issue,
    input  t_ame_instr                   i_instr,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_a1,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_a2,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_a3,
    input  logic [WORD_WIDTH-1:0]        i_rdata_a,
    input  logic [WORD_WIDTH-1:0]        i_rdata_b,
    output logic                         o_free,
    output logic                         o_we,
    output logic [$clog2(MEM_DEPTH)-1:0] o_waddr,
    output logic [WORD_WIDTH-1:0]        o_wdata,
    ame_out_if.source                    o_result
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int VW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;

    // Low 32 bits of a machine word, zero-extended when the word is narrower
    function automatic logic [31:0] f_to32(input logic [WORD_WIDTH-1:0] w);
        logic [VW-1:0] e;
        e = VW'(w);
        return e[31:0];
    endfunction

    // Stage register
    logic                  r_s1_valid;
    t_ame_instr            r_s1;
    logic [AW-1:0]         r_a1;
    logic [AW-1:0]         r_a2;
    logic [AW-1:0]         r_a3;

    // Write that landed together with the stage's memory read
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [WORD_WIDTH-1:0] r_fwd_data;

    // Machine registers
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] n_acc;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_stopped;
    logic                  n_stopped;

    // Result register
    logic                  r_out_valid;
    t_ame_result           r_out;

    logic                  w_fire;
    logic [WORD_WIDTH-1:0] w_op1;
    logic [WORD_WIDTH-1:0] w_op2;
    logic                  w_we_raw;
    logic [AW-1:0]         w_waddr;
    logic [WORD_WIDTH-1:0] w_wdata;
    logic                  w_shown;
    logic [31:0]           w_val;

    // Advance when the result register is empty or being emptied
    assign w_fire = r_s1_valid && (!r_out_valid || o_result.ready);
    assign o_free = !r_s1_valid || w_fire;

    // Forward the concurrent write over stale read data
    assign w_op1 = (r_fwd_valid && r_fwd_addr == r_a1) ? r_fwd_data : i_rdata_a;
    assign w_op2 = (r_fwd_valid && r_fwd_addr == r_a2) ? r_fwd_data : i_rdata_b;

    // Execute one instruction
    always_comb begin
        n_acc     = r_acc;
        n_count   = r_count;
        n_stopped = r_stopped;
        w_we_raw  = 1'b0;
        w_waddr   = r_a1;
        w_wdata   = '0;
        w_shown   = 1'b0;
        w_val     = '0;
        if (!r_stopped) begin
            case (r_s1.func)
                FN_SET: begin
                    w_we_raw = r_s1.first_present;
                    w_wdata  = WORD_WIDTH'(r_s1.immediate);
                end
                FN_LDR: begin
                    if (r_s1.first_present) begin
                        n_acc = w_op1;
                    end
                end
                FN_ADD: begin
                    if (r_s1.first_present && !r_s1.second_present
                            && !r_s1.third_present) begin
                        n_acc = r_acc + w_op1;
                    end else if (r_s1.first_present && r_s1.second_present
                            && !r_s1.third_present) begin
                        n_acc = w_op1 + w_op2;
                    end else if (r_s1.first_present && r_s1.second_present
                            && r_s1.third_present) begin
                        w_we_raw = 1'b1;
                        w_waddr  = r_a3;
                        w_wdata  = w_op1 + w_op2;
                    end
                end
                FN_INC: begin
                    w_we_raw = r_s1.first_present;
                    w_wdata  = w_op1 + WORD_WIDTH'(1);
                end
                FN_DEC: begin
                    w_we_raw = r_s1.first_present;
                    w_wdata  = w_op1 - WORD_WIDTH'(1);
                end
                FN_STR: begin
                    w_we_raw = r_s1.first_present;
                    w_wdata  = r_acc;
                end
                FN_SHW: begin
                    case (r_s1.show_source)
                        SRC_ACC: begin
                            w_shown = 1'b1;
                            w_val   = f_to32(r_acc);
                        end
                        SRC_CNT: begin
                            w_shown = 1'b1;
                            w_val   = r_count;
                        end
                        SRC_MAR, SRC_MDR: begin
                            w_shown = 1'b1;
                        end
                        SRC_RUN: begin
                            w_shown = 1'b1;
                            w_val   = 32'd1;
                        end
                        SRC_MEM: begin
                            if (r_s1.first_present) begin
                                w_shown = 1'b1;
                                w_val   = f_to32(w_op1);
                            end
                        end
                        default: ;
                    endcase
                end
                FN_END: begin
                    n_stopped = 1'b1;
                end
                default: ;
            endcase
            n_count = r_count + CNT_W'(1);
        end
    end

    assign o_we    = w_fire && w_we_raw;
    assign o_waddr = w_waddr;
    assign o_wdata = w_wdata;

    // Stage register: load on issue, drop on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_issue) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1 <= i_instr;
            r_a1 <= i_a1;
            r_a2 <= i_a2;
            r_a3 <= i_a3;
        end
    end

    // Capture the write that coincides with the new read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_issue) begin
            r_fwd_valid <= o_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_fwd_addr <= w_waddr;
            r_fwd_data <= w_wdata;
        end
    end

    // Machine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (w_fire) begin
            r_acc     <= n_acc;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.shown       <= w_shown;
            r_out.shown_value <= w_val;
            r_out.halted      <= n_stopped;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // No memory write once halted
    a_no_write_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !o_we)
        else $error("memory write after halt");

    // Counter frozen once halted
    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> $stable(r_count))
        else $error("instruction counter moved after halt");

    // Every advance leaves a result waiting
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("executed instruction produced no result");

    // A displayed value never comes from a halted step
    a_shown_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.shown) |-> !r_out.halted)
        else $error("shown value reported with halted set");

endmodule

@@ rtl/core/accumulator_machine_execute.sv @@
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Accumulator machine executing one pre-decoded instruction per transaction.
// ----------------------------------------------------------------------------
// After reset the block clears its data memory, one word a cycle, and the
// instruction channel is not ready during that pass. From then on it takes
// one instruction per cycle while results are taken, and returns exactly one
// result per instruction, in order. An instruction's memory operands are read
// in the cycle it is accepted; it then executes once the result register is
// empty or being emptied, and its result is registered in the output
// register. The sustained rate of one instruction per cycle is set by the
// read-modify-write loop through the execute stage, where a write landing in
// the same cycle as the next read is forwarded from the write port. While a
// result waits to be taken, one further instruction is still accepted.
// Addresses are reduced modulo MEM_DEPTH; arithmetic wraps at WORD_WIDTH bits.
// ----------------------------------------------------------------------------
module accumulator_machine_execute import ame_pkg::*; #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ame_in_if.sink   i_instr,
    ame_out_if.source o_result
);

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int RECIP = 65536 / MEM_DEPTH;

    // Reduce an 8-bit operand address modulo the memory depth
    function automatic logic [AW-1:0] f_addr(input logic [7:0] a);
        logic [23:0] prod;
        logic [23:0] q;
        logic [23:0] r;
        prod = 24'(a) * 24'(RECIP);
        q    = prod >> 16;
        r    = 24'(a) - q * 24'(MEM_DEPTH);
        if (r >= 24'(MEM_DEPTH)) begin
            r = r - 24'(MEM_DEPTH);
        end
        if (MEM_DEPTH >= 256) begin
            return AW'(a);
        end
        return AW'(r);
    endfunction

    t_ame_phase            r_phase;
    t_ame_phase            n_phase;
    logic [AW-1:0]         r_clr_addr;
    logic                  w_clearing;

    logic                  w_issue;
    logic [AW-1:0]         w_a1;
    logic [AW-1:0]         w_a2;
    logic [AW-1:0]         w_a3;
    logic                  w_free;
    logic                  w_ex_we;
    logic [AW-1:0]         w_ex_waddr;
    logic [WORD_WIDTH-1:0] w_ex_wdata;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [WORD_WIDTH-1:0] w_ram_wdata;
    logic [WORD_WIDTH-1:0] w_rdata_a;
    logic [WORD_WIDTH-1:0] w_rdata_b;

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CLEAR;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Phase sequencing: leave the clear pass after the last word
    always_comb begin
        n_phase    = r_phase;
        w_clearing = 1'b0;
        case (r_phase)
            PH_CLEAR: begin
                w_clearing = 1'b1;
                if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: ;
            default: n_phase = PH_CLEAR;
        endcase
    end

    // Clear address counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (w_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Accept an instruction and issue its operand reads
    assign i_instr.ready = !w_clearing && w_free;
    assign w_issue       = i_instr.valid && i_instr.ready;
    assign w_a1          = f_addr(i_instr.payload.first_addr);
    assign w_a2          = f_addr(i_instr.payload.second_addr);
    assign w_a3          = f_addr(i_instr.payload.third_addr);

    // Write port: clear pass or execute write-back
    assign w_ram_we    = w_clearing || w_ex_we;
    assign w_ram_waddr = w_clearing ? r_clr_addr : w_ex_waddr;
    assign w_ram_wdata = w_clearing ? '0 : w_ex_wdata;

    ame_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   (w_ram_waddr),
        .i_wdata   (w_ram_wdata),
        .i_re      (w_issue),
        .i_raddr_a (w_a1),
        .i_raddr_b (w_a2),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    ame_exec #(
        .MEM_DEPTH  (MEM_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (w_issue),
        .i_instr   (i_instr.payload),
        .i_a1      (w_a1),
        .i_a2      (w_a2),
        .i_a3      (w_a3),
        .i_rdata_a (w_rdata_a),
        .i_rdata_b (w_rdata_b),
        .o_free    (w_free),
        .o_we      (w_ex_we),
        .o_waddr   (w_ex_waddr),
        .o_wdata   (w_ex_wdata),
        .o_result  (o_result)
    );

    // No instruction enters while the memory is being cleared
    a_no_issue_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLEAR) |-> (!w_issue && !w_ex_we))
        else $error("instruction activity during memory clear");

endmodule
